@@ src/u8n1_pkg.sv @@
// Shared types and constants of the 8N1 serial transceiver.
package u8n1_pkg;

    localparam int unsigned DATA_BITS   = 8;
    localparam int unsigned FRAME_BITS  = DATA_BITS + 2;
    localparam int unsigned TIMER_W     = 16;
    localparam int unsigned CNT_W       = 4;
    localparam int unsigned CFG_IDX_W   = 2;
    localparam int unsigned CFG_DATA_W  = 16;
    localparam int unsigned IN_TDATA_W  = 16;
    localparam int unsigned OUT_TDATA_W = 16;

    typedef logic [TIMER_W-1:0]    t_timer;
    typedef logic [CNT_W-1:0]      t_cnt;
    typedef logic [DATA_BITS-1:0]  t_byte;
    typedef logic [FRAME_BITS-1:0] t_frame;

    localparam t_timer TIMER_ONE  = t_timer'(1);
    localparam t_cnt   CNT_ONE    = t_cnt'(1);
    localparam t_cnt   CNT_DATA   = t_cnt'(DATA_BITS);
    localparam t_cnt   CNT_FRAME  = t_cnt'(FRAME_BITS);
    localparam t_frame FRAME_ONES = '1;

    localparam t_timer BIT_PERIOD_RST   = t_timer'(434);
    localparam t_timer START_OFFSET_RST = t_timer'(144);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BIT_PERIOD   = 2'd0,
        CFG_START_OFFSET = 2'd1
    } t_cfg_idx;

    // input item, first field in the highest bits
    typedef struct packed {
        t_byte tx_byte;
        logic  tx_valid;
        logic  rx_level;
    } t_item;

    typedef struct packed {
        logic line;
        logic ready;
    } t_tx_res;

    typedef struct packed {
        logic  valid;
        t_byte data;
    } t_rx_res;

    // result item, first field in the highest bits
    typedef struct packed {
        t_byte rx_byte;
        logic  rx_valid;
        logic  tx_ready;
        logic  tx_line;
    } t_result;

endpackage

@@ src/u8n1_tx.sv @@
// Transmit framer: start bit, data bits LSB first, stop bit, one tick per item.
module u8n1_tx (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_offer,
    input  u8n1_pkg::t_byte     i_byte,
    input  u8n1_pkg::t_timer    i_bit_period,
    output u8n1_pkg::t_tx_res   o_res
);

    logic              r_active, n_active;
    u8n1_pkg::t_timer  r_timer,  n_timer;
    u8n1_pkg::t_cnt    r_cnt,    n_cnt;
    u8n1_pkg::t_frame  r_shift,  n_shift;

    logic              w_accept;
    logic              w_active0;
    u8n1_pkg::t_timer  w_timer0, w_timer1;
    u8n1_pkg::t_cnt    w_cnt0,   w_cnt1;
    u8n1_pkg::t_frame  w_shift0;

    always_comb begin
        w_accept  = !r_active && i_offer;
        w_active0 = r_active || w_accept;
        w_timer0  = w_accept ? '0 : r_timer;
        w_cnt0    = w_accept ? '0 : r_cnt;
        w_shift0  = w_accept ? {1'b1, i_byte, 1'b0} : r_shift;
        w_timer1  = w_timer0 + u8n1_pkg::TIMER_ONE;
        w_cnt1    = w_cnt0 + u8n1_pkg::CNT_ONE;

        n_active = w_active0;
        n_timer  = w_timer0;
        n_cnt    = w_cnt0;
        n_shift  = w_shift0;
        if (w_active0) begin
            // a period of zero behaves as one: the compare is always true
            if (w_timer1 >= i_bit_period) begin
                n_timer = '0;
                n_shift = {1'b1, w_shift0[u8n1_pkg::FRAME_BITS-1:1]};
                n_cnt   = w_cnt1;
                if (w_cnt1 >= u8n1_pkg::CNT_FRAME) begin
                    n_active = 1'b0;
                    n_cnt    = '0;
                    n_shift  = u8n1_pkg::FRAME_ONES;
                end
            end else begin
                n_timer = w_timer1;
            end
        end
    end

    always_comb begin
        o_res.line  = w_shift0[0];
        o_res.ready = w_accept;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_timer  <= '0;
            r_cnt    <= '0;
            r_shift  <= u8n1_pkg::FRAME_ONES;
        end else if (i_en) begin
            r_active <= n_active;
            r_timer  <= n_timer;
            r_cnt    <= n_cnt;
            r_shift  <= n_shift;
        end
    end

`ifndef ASSERT_OFF
    a_idle_line_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_active |-> (r_shift == u8n1_pkg::FRAME_ONES && r_cnt == '0))
        else $error("tx idle with frame bits pending");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt < u8n1_pkg::CNT_FRAME)
        else $error("tx bit count past frame length");
`endif

endmodule

@@ src/u8n1_rx.sv @@
// Receive sampler: falling edge arms it, data bits sampled at offset plus k periods.
module u8n1_rx (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_level,
    input  u8n1_pkg::t_timer    i_bit_period,
    input  u8n1_pkg::t_timer    i_start_offset,
    output u8n1_pkg::t_rx_res   o_res
);

    logic              r_active, n_active;
    logic              r_prev,   n_prev;
    u8n1_pkg::t_timer  r_timer,  n_timer;
    u8n1_pkg::t_cnt    r_cnt,    n_cnt;
    u8n1_pkg::t_byte   r_shift,  n_shift;

    u8n1_pkg::t_timer  w_timer1;
    logic              w_valid;

    always_comb begin
        w_timer1 = r_timer + u8n1_pkg::TIMER_ONE;
        n_active = r_active;
        n_timer  = r_timer;
        n_cnt    = r_cnt;
        n_shift  = r_shift;
        n_prev   = i_level;
        w_valid  = 1'b0;
        if (r_active) begin
            if (r_cnt == '0) begin
                // waiting out the start offset
                if (w_timer1 >= i_start_offset) begin
                    n_timer = '0;
                    n_cnt   = u8n1_pkg::CNT_ONE;
                end else begin
                    n_timer = w_timer1;
                end
            end else if (w_timer1 >= i_bit_period) begin
                n_timer = '0;
                n_shift = {i_level, r_shift[u8n1_pkg::DATA_BITS-1:1]};
                if (r_cnt >= u8n1_pkg::CNT_DATA) begin
                    w_valid  = 1'b1;
                    n_active = 1'b0;
                    n_cnt    = '0;
                end else begin
                    n_cnt = r_cnt + u8n1_pkg::CNT_ONE;
                end
            end else begin
                n_timer = w_timer1;
            end
        end else if (r_prev && !i_level) begin
            n_active = 1'b1;
            n_timer  = '0;
            n_shift  = '0;
            n_cnt    = (i_start_offset == '0) ? u8n1_pkg::CNT_ONE : '0;
        end
    end

    always_comb begin
        o_res.valid = w_valid;
        o_res.data  = w_valid ? n_shift : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_prev   <= 1'b1;
            r_timer  <= '0;
            r_cnt    <= '0;
            r_shift  <= '0;
        end else if (i_en) begin
            r_active <= n_active;
            r_prev   <= n_prev;
            r_timer  <= n_timer;
            r_cnt    <= n_cnt;
            r_shift  <= n_shift;
        end
    end

`ifndef ASSERT_OFF
    a_idle_cnt_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_active |-> (r_cnt == '0))
        else $error("rx idle with bit count set");
`endif

endmodule

@@ src/u8n1_obuf.sv @@
// Result output register with one skid entry.
module u8n1_obuf (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    input  u8n1_pkg::t_result           i_data,
    output logic                        o_full,
    output logic                        o_valid,
    input  logic                        i_ready,
    output u8n1_pkg::t_result           o_data
);

    logic               r_out_valid,  n_out_valid;
    logic               r_skid_valid, n_skid_valid;
    u8n1_pkg::t_result  r_out_data,   n_out_data;
    u8n1_pkg::t_result  r_skid_data,  n_skid_data;
    logic               w_pop;

    always_comb begin
        w_pop        = r_out_valid && i_ready;
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out_data   = r_out_data;
        n_skid_data  = r_skid_data;
        if (w_pop) begin
            if (r_skid_valid) begin
                n_out_data   = r_skid_data;
                n_skid_valid = i_push;
                n_skid_data  = i_data;
            end else begin
                n_out_valid = i_push;
                n_out_data  = i_data;
            end
        end else if (i_push) begin
            if (!r_out_valid) begin
                n_out_valid = 1'b1;
                n_out_data  = i_data;
            end else begin
                n_skid_valid = 1'b1;
                n_skid_data  = i_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data  <= n_out_data;
        r_skid_data <= n_skid_data;
    end

    assign o_full  = r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;

`ifndef ASSERT_OFF
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held with empty output register");
`endif

endmodule

@@ src/uart_8n1_transceiver.sv @@
// Top level of the 8N1 serial transceiver: input register, line logic, result buffer.
//
// Each transfer on the s_axis side is one clock tick of the serial line
// sampler: the current receive line level plus an optional byte to send.
// Each such transfer produces exactly one result transfer on m_axis: the
// transmit line level for that tick, whether the offered byte was taken,
// and a received byte when one completes on that tick.
// Path: a transfer is captured in the input register, passes the line logic
// and is captured in the output register of the result buffer, which drives m_axis.
// Throughput: one transfer per cycle while m_axis does not stall; the transmit
// and receive state updates are register loops of one 16-bit timer add each.
// s_axis_tready depends only on registers: it drops when the input
// register is full and the skid entry of the output buffer is occupied,
// so a stalled m_axis holds up to three transfers in flight.
// Reset (synchronous, active low) idles both directions, drives the
// transmit line high, and loads bit_period 434 and start_offset 144.
// Configuration writes take effect at the write edge; write them only
// while no transfer is in flight.
module uart_8n1_transceiver (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration
    input  logic                                i_cfg_we,
    input  logic [u8n1_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [u8n1_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // input ticks
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [0] rx_level, [1] tx_valid, [9:2] tx_byte, [15:10] unused
    input  logic [u8n1_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // results
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [0] tx_line, [1] tx_ready, [2] rx_valid, [10:3] rx_byte, [15:11] zero
    output logic [u8n1_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

    u8n1_pkg::t_timer   r_bit_period;
    u8n1_pkg::t_timer   r_start_offset;

    logic               r_in_valid;
    u8n1_pkg::t_item    r_in_data;

    logic               w_advance;
    logic               w_obuf_full;
    u8n1_pkg::t_tx_res  w_tx;
    u8n1_pkg::t_rx_res  w_rx;
    u8n1_pkg::t_result  w_result;
    u8n1_pkg::t_result  w_out_data;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_period   <= u8n1_pkg::BIT_PERIOD_RST;
            r_start_offset <= u8n1_pkg::START_OFFSET_RST;
        end else if (i_cfg_we) begin
            unique case (u8n1_pkg::t_cfg_idx'(i_cfg_idx))
                u8n1_pkg::CFG_BIT_PERIOD:   r_bit_period   <= i_cfg_data;
                u8n1_pkg::CFG_START_OFFSET: r_start_offset <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input register
    assign w_advance     = r_in_valid && !w_obuf_full;
    assign s_axis_tready = !r_in_valid || !w_obuf_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_data <= s_axis_tdata[$bits(u8n1_pkg::t_item)-1:0];
        end
    end

    u8n1_tx u_tx (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (w_advance),
        .i_offer      (r_in_data.tx_valid),
        .i_byte       (r_in_data.tx_byte),
        .i_bit_period (r_bit_period),
        .o_res        (w_tx)
    );

    u8n1_rx u_rx (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (w_advance),
        .i_level        (r_in_data.rx_level),
        .i_bit_period   (r_bit_period),
        .i_start_offset (r_start_offset),
        .o_res          (w_rx)
    );

    always_comb begin
        w_result.tx_line  = w_tx.line;
        w_result.tx_ready = w_tx.ready;
        w_result.rx_valid = w_rx.valid;
        w_result.rx_byte  = w_rx.data;
    end

    u8n1_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_advance),
        .i_data  (w_result),
        .o_full  (w_obuf_full),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (w_out_data)
    );

    assign m_axis_tdata = u8n1_pkg::OUT_TDATA_W'(w_out_data);

`ifndef ASSERT_OFF
    a_ready_when_skid_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_obuf_full |-> s_axis_tready)
        else $error("input stalled with room in output buffer");
`endif

endmodule
